/* sv/lirs_pkg.sv */
//------------------------------------------------------------------------------
// lirs_pkg: shared types and constants of the linear interpolation resampler
// Register map, fixed widths, and the command/status bundles between the
// controller and the datapath.
//------------------------------------------------------------------------------
`default_nettype none

package lirs_pkg;

	// Rate registers and phase accounting
	localparam int RATE_W  = 18;
	localparam int PHASE_W = RATE_W + 1;
	localparam int CNT_W   = PHASE_W + 1;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [0:0] REG_IN_RATE  = 1'b0;
	localparam logic [0:0] REG_OUT_RATE = 1'b1;

	localparam logic [RATE_W-1:0] IN_RATE_RST  = 18'd48000;
	localparam logic [RATE_W-1:0] OUT_RATE_RST = 18'd48000;

	// Which quotient the shared divider is working on
	typedef enum logic [1:0] {
		DIV_N1,    // outputs between previous and current sample
		DIV_FRAC,  // first interpolation fraction
		DIV_STEP,  // fraction increment per output
		DIV_N2     // repeats of the final sample
	} div_sel_t;

	// Controller -> datapath
	typedef struct packed {
		logic     div_start;
		logic     div_save;
		div_sel_t div_sel;
		logic     plan;
		logic     put;
		logic     commit;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic have_prev;
		logic fin;
		logic p0_lt_orr;
		logic p1_lt_orr;
		logic div_done;
		logic emit_more;
		logic fire;
	} sts_t;

endpackage

`default_nettype wire

/* sv/lirs_div.sv */
//------------------------------------------------------------------------------
// lirs_div: restoring divider, one quotient bit per cycle
// Unsigned NUM_W / DEN_W division; quotient and remainder hold after done.
//------------------------------------------------------------------------------
`default_nettype none

module lirs_div #(
	parameter int NUM_W = 35,
	parameter int DEN_W = 18
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quot,
	output logic [DEN_W-1:0]      rem
);

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic             ge;

	// Shift in next dividend bit, try subtracting the divisor
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* sv/lirs_dp.sv */
//------------------------------------------------------------------------------
// lirs_dp: resampler datapath
// Stream state, output counts, incremental fraction tracking, interpolation
// multiplier and the output register.
//------------------------------------------------------------------------------
`default_nettype none

module lirs_dp #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16,
	parameter int MAX_RESULTS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [lirs_pkg::RATE_W-1:0]     in_rate,
	input  wire logic [lirs_pkg::RATE_W-1:0]     out_rate,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]   sample_in,
	input  wire logic                            final_sample,
	input  wire logic                            out_stall,
	output logic                                 out_valid,
	output logic signed [SAMPLE_BITS-1:0]        sample_out,
	output logic                                 run_last,
	output logic                                 stream_end,
	output logic                                 truncated,
	input  wire lirs_pkg::cmd_t                  cmd,
	output lirs_pkg::sts_t                       sts
);

	localparam int RW    = lirs_pkg::RATE_W;
	localparam int PHW   = lirs_pkg::PHASE_W;
	localparam int CNW   = lirs_pkg::CNT_W;
	localparam int NUM_W = PHW + FRAC_BITS;
	localparam int KW    = $clog2(MAX_RESULTS + 1);
	localparam int PW    = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int XW    = SAMPLE_BITS + 2;
	localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	// Stream state
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic                          have_q;
	logic [PHW-1:0]                phase_q;

	// Current item
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic                          fin_q;
	logic [CNW-1:0]                n1_q;
	logic [CNW-1:0]                n2_q;
	logic [PHW-1:0]                p1_q;
	logic [KW-1:0]                 emit_q;
	logic [KW-1:0]                 k_q;
	logic                          trunc_q;

	// Fraction tracking: p = frac*orr + frem, scaled by 2^FRAC_BITS
	logic [FRAC_BITS-1:0]          frac_q;
	logic [RW-1:0]                 frem_q;
	logic [FRAC_BITS-1:0]          qstep_q;
	logic [RW-1:0]                 rstep_q;

	logic signed [PW-1:0]          prod_s1;

	// Output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          run_last_q;
	logic                          stream_end_q;
	logic                          truncated_q;

	// Effective rates, zero reads as one
	logic [RW-1:0] ir;
	logic [RW-1:0] orr;
	assign ir  = (in_rate == '0) ? RW'(1) : in_rate;
	assign orr = (out_rate == '0) ? RW'(1) : out_rate;

	logic accept;
	logic fire;
	assign accept = in_valid && !in_stall;
	assign fire   = cmd.put && (!out_valid_q || !out_stall);

	logic p0_lt_orr;
	logic p1_lt_orr;
	assign p0_lt_orr = (phase_q < {1'b0, orr});
	assign p1_lt_orr = (p1_q < {1'b0, orr});

	// Divider operand select
	logic [PHW-1:0]   d1;
	logic [PHW-1:0]   d2;
	logic [NUM_W-1:0] div_num;
	logic [RW-1:0]    div_den;
	logic             div_done;
	logic [NUM_W-1:0] div_quot;
	logic [RW-1:0]    div_rem;

	assign d1 = {1'b0, orr} - phase_q;
	assign d2 = {1'b0, orr} - p1_q;

	always_comb begin
		case (cmd.div_sel)
			lirs_pkg::DIV_N1: begin
				div_num = {{FRAC_BITS{1'b0}}, d1};
				div_den = ir;
			end
			lirs_pkg::DIV_FRAC: begin
				div_num = {phase_q, {FRAC_BITS{1'b0}}};
				div_den = orr;
			end
			lirs_pkg::DIV_STEP: begin
				div_num = {1'b0, ir, {FRAC_BITS{1'b0}}};
				div_den = orr;
			end
			lirs_pkg::DIV_N2: begin
				div_num = {{FRAC_BITS{1'b0}}, d2};
				div_den = ir;
			end
			default: begin
				div_num = '0;
				div_den = ir;
			end
		endcase
	end

	lirs_div #(
		.NUM_W(NUM_W),
		.DEN_W(RW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot),
		.rem   (div_rem)
	);

	// Ceiling count from quotient and remainder
	logic [CNW-1:0] ceil_cnt;
	assign ceil_cnt = div_quot[CNW-1:0] + CNW'(div_rem != '0);

	// Emission plan
	logic [CNW-1:0] total;
	logic           over;
	assign total = n1_q + n2_q;
	assign over  = (total > CNW'(MAX_RESULTS));

	// Next fraction: add step, carry when remainders overflow orr
	logic [RW:0] rsum;
	logic        wrap;
	assign rsum = {1'b0, frem_q} + {1'b0, rstep_q};
	assign wrap = (rsum >= {1'b0, orr});

	// Interpolation: prev + floor((diff*frac + half) / 2^FRAC_BITS)
	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [PW-1:0]          rnd;
	logic signed [PW-1:0]          adj;
	logic signed [XW-1:0]          interp_x;
	logic signed [SAMPLE_BITS-1:0] value;
	logic                          is_interp;
	logic [KW-1:0]                 k_next;

	assign diff      = {smp_q[SAMPLE_BITS-1], smp_q} - {prev_q[SAMPLE_BITS-1], prev_q};
	assign rnd       = prod_s1 + HALF;
	assign adj       = rnd >>> FRAC_BITS;
	assign interp_x  = {{2{prev_q[SAMPLE_BITS-1]}}, prev_q} + adj[XW-1:0];
	assign is_interp = ({{(CNW-KW){1'b0}}, k_q} < n1_q);
	assign value     = is_interp ? interp_x[SAMPLE_BITS-1:0] : smp_q;
	assign k_next    = k_q + KW'(1);

	// Multiplier stage, recomputed every cycle from the current fraction
	always_ff @(posedge clk) begin
		prod_s1 <= diff * $signed({1'b0, frac_q});
	end

	// Item and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			have_q  <= 1'b0;
			phase_q <= '0;
			fin_q   <= 1'b0;
			n1_q    <= '0;
			n2_q    <= '0;
			p1_q    <= '0;
			emit_q  <= '0;
			k_q     <= '0;
			trunc_q <= 1'b0;
		end else begin
			if (accept) begin
				fin_q <= final_sample;
				n1_q  <= '0;
				n2_q  <= '0;
				p1_q  <= (have_q && !p0_lt_orr) ? (phase_q - {1'b0, orr}) : '0;
			end
			if (cmd.div_save) begin
				case (cmd.div_sel)
					lirs_pkg::DIV_N1: begin
						n1_q <= ceil_cnt;
						p1_q <= (div_rem == '0) ? '0 : {1'b0, ir - div_rem};
					end
					lirs_pkg::DIV_N2: n2_q <= ceil_cnt;
					default: ;
				endcase
			end
			if (cmd.plan) begin
				trunc_q <= over;
				emit_q  <= over ? KW'(MAX_RESULTS) : total[KW-1:0];
				k_q     <= '0;
			end
			if (fire) begin
				k_q <= k_next;
			end
			if (cmd.commit) begin
				if (fin_q) begin
					prev_q  <= '0;
					have_q  <= 1'b0;
					phase_q <= '0;
				end else begin
					prev_q  <= smp_q;
					have_q  <= 1'b1;
					phase_q <= p1_q;
				end
			end
		end
	end

	// Sample latch and fraction registers
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample_in;
		end
		if (cmd.div_save) begin
			case (cmd.div_sel)
				lirs_pkg::DIV_FRAC: begin
					frac_q <= div_quot[FRAC_BITS-1:0];
					frem_q <= div_rem;
				end
				lirs_pkg::DIV_STEP: begin
					qstep_q <= div_quot[FRAC_BITS-1:0];
					rstep_q <= div_rem;
				end
				default: ;
			endcase
		end else if (fire) begin
			frac_q <= frac_q + qstep_q + FRAC_BITS'(wrap);
			frem_q <= wrap ? RW'(rsum - {1'b0, orr}) : rsum[RW-1:0];
		end
	end

	// Output register: holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_out_q <= value;
			run_last_q   <= (k_next == emit_q);
			stream_end_q <= (k_next == emit_q) && fin_q;
			truncated_q  <= trunc_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign run_last   = run_last_q;
	assign stream_end = stream_end_q;
	assign truncated  = truncated_q;

	// Status to controller
	assign sts.have_prev = have_q;
	assign sts.fin       = fin_q;
	assign sts.p0_lt_orr = p0_lt_orr;
	assign sts.p1_lt_orr = p1_lt_orr;
	assign sts.div_done  = div_done;
	assign sts.emit_more = (k_q < emit_q);
	assign sts.fire      = fire;

endmodule

`default_nettype wire

/* sv/lirs_ctrl.sv */
//------------------------------------------------------------------------------
// lirs_ctrl: resampler controller
// Sequences the divisions that size the output run, then paces the results
// into the output register and updates stream state.
//------------------------------------------------------------------------------
`default_nettype none

module lirs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output lirs_pkg::cmd_t      cmd,
	input  wire lirs_pkg::sts_t sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK1,
		S_W_N1,
		S_GO_FR,
		S_W_FR,
		S_GO_ST,
		S_W_ST,
		S_CHK2,
		S_W_N2,
		S_PREP,
		S_PLAN,
		S_EMIT,
		S_PUT,
		S_COMMIT
	} state_t;

	state_t         state_q;
	logic           stall_q;
	lirs_pkg::cmd_t cmd_q;

	// State and registered commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
			cmd_q   <= '0;
		end else begin
			// one-cycle commands
			cmd_q.div_start <= 1'b0;
			cmd_q.div_save  <= 1'b0;
			cmd_q.plan      <= 1'b0;
			cmd_q.commit    <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						stall_q <= 1'b1;
						state_q <= S_CHK1;
					end
				end
				S_CHK1: begin
					if (sts.have_prev && sts.p0_lt_orr) begin
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= lirs_pkg::DIV_N1;
						state_q         <= S_W_N1;
					end else begin
						state_q <= S_CHK2;
					end
				end
				S_W_N1: begin
					if (sts.div_done) begin
						cmd_q.div_save <= 1'b1;
						state_q        <= S_GO_FR;
					end
				end
				S_GO_FR: begin
					cmd_q.div_start <= 1'b1;
					cmd_q.div_sel   <= lirs_pkg::DIV_FRAC;
					state_q         <= S_W_FR;
				end
				S_W_FR: begin
					if (sts.div_done) begin
						cmd_q.div_save <= 1'b1;
						state_q        <= S_GO_ST;
					end
				end
				S_GO_ST: begin
					cmd_q.div_start <= 1'b1;
					cmd_q.div_sel   <= lirs_pkg::DIV_STEP;
					state_q         <= S_W_ST;
				end
				S_W_ST: begin
					if (sts.div_done) begin
						cmd_q.div_save <= 1'b1;
						state_q        <= S_CHK2;
					end
				end
				S_CHK2: begin
					if (sts.fin && sts.p1_lt_orr) begin
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= lirs_pkg::DIV_N2;
						state_q         <= S_W_N2;
					end else begin
						state_q <= S_PREP;
					end
				end
				S_W_N2: begin
					if (sts.div_done) begin
						cmd_q.div_save <= 1'b1;
						state_q        <= S_PREP;
					end
				end
				S_PREP: begin
					cmd_q.plan <= 1'b1;
					state_q    <= S_PLAN;
				end
				S_PLAN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (sts.emit_more) begin
						cmd_q.put <= 1'b1;
						state_q   <= S_PUT;
					end else begin
						cmd_q.commit <= 1'b1;
						state_q      <= S_COMMIT;
					end
				end
				S_PUT: begin
					// request held until the output register takes it
					if (sts.fire) begin
						cmd_q.put <= 1'b0;
						state_q   <= S_EMIT;
					end
				end
				S_COMMIT: begin
					stall_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall = stall_q;
	assign cmd      = cmd_q;

endmodule

`default_nettype wire

/* sv/linear_interp_resampler.sv */
//------------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample rate converter
// One channel of Q1.15 samples from in_rate to out_rate, with an APB-style
// port for the two rate registers.
//------------------------------------------------------------------------------
// Each item: up to four divisions on the one-bit-per-cycle divider, then its
//   results enter the output register one after another.
// One item at a time; the next transfer is taken once the last result has
//   entered the output register and the stream state is committed.
// Reset: arst_n clears stream state and rates go to 48000 / 48000.
`default_nettype none

module linear_interp_resampler #(
	parameter int MAX_RESULTS = 16,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lirs_pkg::ADDR_W-1:0]       paddr,
	input  wire logic [lirs_pkg::DATA_W-1:0]       pwdata,
	output logic [lirs_pkg::DATA_W-1:0]            prdata,
	output logic                                   pready,
	// input samples
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]     sample_in,
	input  wire logic                              final_sample,
	// output samples
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]          sample_out,
	output logic                                   run_last,
	output logic                                   stream_end,
	output logic                                   truncated
);

	localparam int RW = lirs_pkg::RATE_W;
	localparam int DW = lirs_pkg::DATA_W;

	logic [RW-1:0] in_rate_q;
	logic [RW-1:0] out_rate_q;
	logic          wr_en;

	lirs_pkg::cmd_t cmd;
	lirs_pkg::sts_t sts;

	// Register writes
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rate_q  <= lirs_pkg::IN_RATE_RST;
			out_rate_q <= lirs_pkg::OUT_RATE_RST;
		end else if (wr_en) begin
			unique case (paddr[2:2])
				lirs_pkg::REG_IN_RATE:  in_rate_q  <= pwdata[RW-1:0];
				lirs_pkg::REG_OUT_RATE: out_rate_q <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[2:2])
			lirs_pkg::REG_IN_RATE:  prdata = {{(DW-RW){1'b0}}, in_rate_q};
			lirs_pkg::REG_OUT_RATE: prdata = {{(DW-RW){1'b0}}, out_rate_q};
			default:                prdata = '0;
		endcase
	end

	lirs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	lirs_dp #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.MAX_RESULTS(MAX_RESULTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_rate     (in_rate_q),
		.out_rate    (out_rate_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_in   (sample_in),
		.final_sample(final_sample),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.sample_out  (sample_out),
		.run_last    (run_last),
		.stream_end  (stream_end),
		.truncated   (truncated),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

`default_nettype wire

/* sv/lirs_chk.sv */
//------------------------------------------------------------------------------
// lirs_chk: port-level checks for the resampler
// Watches the sample channels and is bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module lirs_chk #(
	parameter int SAMPLE_BITS = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic signed [SAMPLE_BITS-1:0] sample_out,
	input wire logic                          run_last,
	input wire logic                          stream_end
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(run_last))
		else $error("stalled result changed");

	// End of stream only on the last result of an item
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_end |-> run_last)
		else $error("stream_end without run_last");

	// One item at a time: an input transfer closes the input side
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

	// Item still running while its results are not finished
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_last |=> in_stall)
		else $error("input open in the middle of a run");

	// Reset quiets both channels
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("channel active in reset");

endmodule

bind linear_interp_resampler lirs_chk #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_lirs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.sample_out(sample_out),
	.run_last  (run_last),
	.stream_end(stream_end)
);

`default_nettype wire

/* tb/resample_checker.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// resample_checker: output predictor and scoreboard for the resampler
// Follows the rate register writes and every accepted input sample. It keeps
// its own copy of the stream state, works out the interpolated samples that
// each input should produce, and compares every accepted output against
// the oldest outstanding expectation.
//------------------------------------------------------------------------------

module resample_checker #(
	parameter int MAX_RESULTS = 16,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [lirs_pkg::ADDR_W-1:0]         paddr,
	input  logic [lirs_pkg::DATA_W-1:0]         pwdata,
	// input channel
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  logic                                final_sample,
	// output channel
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample_out,
	input  logic                                run_last,
	input  logic                                stream_end,
	input  logic                                truncated,
	// status to the test top
	output int                                  errors,
	output int                                  pending
);

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          run_last;
		logic                          stream_end;
		logic                          truncated;
	} out_sample_t;

	// Predicted output samples, oldest first
	out_sample_t expected_samples[$];

	// Shadow of the rate registers and of the stream state
	logic [lirs_pkg::RATE_W-1:0]   in_rate_q;
	logic [lirs_pkg::RATE_W-1:0]   out_rate_q;
	logic signed [SAMPLE_BITS-1:0] prev_sample_q;
	logic                          have_prev_q;
	logic [lirs_pkg::PHASE_W-1:0]  phase_q;

	int fail_count;

	assign errors = fail_count;

	// s0 + round((s1 - s0) * frac), frac = p / den in FRAC_BITS bits
	function automatic logic signed [SAMPLE_BITS-1:0] lerp_sample(
		input longint s0, input longint s1, input longint p, input longint den);
		longint frac;
		longint t;
		longint v;
		longint hi;
		frac = (p <<< FRAC_BITS) / den;
		t = (s1 - s0) * frac + (longint'(1) <<< (FRAC_BITS - 1));
		v = s0 + (t >>> FRAC_BITS);
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		if (v > hi)
			v = hi;
		if (v < -hi - 1)
			v = -hi - 1;
		return v[SAMPLE_BITS-1:0];
	endfunction

	// Append one expectation at the tail
	function automatic void add_expected(input out_sample_t r);
		expected_samples = {expected_samples, r};
	endfunction

	// Outputs caused by one input sample; advances the shadow state
	function automatic void predict_outputs(input logic signed [SAMPLE_BITS-1:0] s,
		input logic fin);
		logic signed [SAMPLE_BITS-1:0] vals [MAX_RESULTS];
		longint ir;
		longint orr;
		longint p;
		int     n;
		int     kept;
		out_sample_t r;
		ir  = (in_rate_q == '0) ? 1 : longint'(in_rate_q);
		orr = (out_rate_q == '0) ? 1 : longint'(out_rate_q);
		p   = longint'(phase_q);
		n   = 0;

		// outputs between the previous sample and this one
		if (!have_prev_q) begin
			p = 0;
		end else begin
			while (p < orr) begin
				if (n < MAX_RESULTS)
					vals[n] = lerp_sample(longint'(prev_sample_q), longint'(s), p, orr);
				n++;
				p += ir;
			end
			p -= orr;
		end

		// end of stream: hold the last sample for outputs past it
		if (fin) begin
			while (p < orr) begin
				if (n < MAX_RESULTS)
					vals[n] = s;
				n++;
				p += ir;
			end
			prev_sample_q = '0;
			have_prev_q   = 1'b0;
			phase_q       = '0;
		end else begin
			prev_sample_q = s;
			have_prev_q   = 1'b1;
			phase_q       = p[lirs_pkg::PHASE_W-1:0];
		end

		kept = (n > MAX_RESULTS) ? MAX_RESULTS : n;
		for (int k = 0; k < kept; k++) begin
			r.sample     = vals[k];
			r.run_last   = (k == kept - 1);
			r.stream_end = fin && (k == kept - 1);
			r.truncated  = (n > MAX_RESULTS);
			add_expected(r);
		end
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fail_count++;
		end
	endtask

	// Follow register writes, predict on input transfers, check output transfers
	always @(posedge clk or negedge arst_n) begin
		out_sample_t want;
		if (!arst_n) begin
			in_rate_q     = lirs_pkg::IN_RATE_RST;
			out_rate_q    = lirs_pkg::OUT_RATE_RST;
			prev_sample_q = '0;
			have_prev_q   = 1'b0;
			phase_q       = '0;
			fail_count    = 0;
			expected_samples.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[lirs_pkg::ADDR_W-1:2])
					lirs_pkg::REG_IN_RATE:  in_rate_q  = pwdata[lirs_pkg::RATE_W-1:0];
					lirs_pkg::REG_OUT_RATE: out_rate_q = pwdata[lirs_pkg::RATE_W-1:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall)
				predict_outputs(sample_in, final_sample);

			if (out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected output transfer, expected none, actual sample %0d",
						$time, sample_out);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					check_field("sample_out", int'(want.sample), int'(sample_out));
					check_field("run_last", int'(want.run_last), int'(run_last));
					check_field("stream_end", int'(want.stream_end), int'(stream_end));
					check_field("truncated", int'(want.truncated), int'(truncated));
				end
			end

			pending <= expected_samples.size();
		end
	end

endmodule

/* tb/linear_interp_resampler_test.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// linear_interp_resampler_test: stimulus and verdict for the resampler
// Programs a series of rate pairs, from the register extremes to common audio
// rates, and sends directed and random sample streams with random gaps on the
// input side and random stalls on the output side. A checker beside the block
// predicts and compares every output transfer.
//------------------------------------------------------------------------------

module linear_interp_resampler_test;

	localparam int SAMPLE_BITS   = 16;
	localparam int IDLE_PCT      = 9;
	localparam int SETTLE_CYCLES = 250;
	localparam int RANDOM_ITEMS  = 210;

	logic                              clk          = 1'b0;
	logic                              arst_n;
	logic                              psel         = 1'b0;
	logic                              penable      = 1'b0;
	logic                              pwrite       = 1'b0;
	logic [lirs_pkg::ADDR_W-1:0]       paddr        = '0;
	logic [lirs_pkg::DATA_W-1:0]       pwdata       = '0;
	logic [lirs_pkg::DATA_W-1:0]       prdata;
	logic                              pready;
	logic                              in_valid     = 1'b0;
	logic                              in_stall;
	logic signed [SAMPLE_BITS-1:0]     sample_in    = '0;
	logic                              final_sample = 1'b0;
	logic                              out_valid;
	logic                              out_stall    = 1'b0;
	logic signed [SAMPLE_BITS-1:0]     sample_out;
	logic                              run_last;
	logic                              stream_end;
	logic                              truncated;

	// no sender gaps and no output stalls while set
	logic quiet = 1'b0;

	int errors;
	int pending;

	linear_interp_resampler dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_stall, .sample_in, .final_sample,
		.out_valid, .out_stall, .sample_out, .run_last, .stream_end, .truncated
	);

	resample_checker u_checker (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_valid, .in_stall, .sample_in, .final_sample,
		.out_valid, .out_stall, .sample_out, .run_last, .stream_end, .truncated,
		.errors, .pending
	);

	always #5 clk = ~clk;

	// Reset once, at the start
	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Output side stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// One input transfer, after an optional random gap
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic fin);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_in    <= s;
		final_sample <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop sending, wait for all predicted outputs, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [0:0] idx, input int unsigned value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_rates(input int unsigned ir, input int unsigned orr);
		drain();
		apb_write(lirs_pkg::REG_IN_RATE, ir);
		apb_write(lirs_pkg::REG_OUT_RATE, orr);
	endtask

	function automatic int unsigned pick_rate();
		int unsigned common_rates [10] = '{8000, 11025, 16000, 22050, 32000,
			44100, 48000, 88200, 96000, 192000};
		if ($urandom_range(9) < 6)
			return common_rates[$urandom_range(9)];
		return $urandom_range(192000, 1);
	endfunction

	// Mostly random, with the full-scale values and the codes around zero
	function automatic logic [SAMPLE_BITS-1:0] draw_sample();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return ($urandom_range(1) != 0) ? 16'h0000 : 16'hFFFF;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	initial begin
		int unsigned ir;
		int unsigned orr;
		int          items;
		int          streams;
		int          len;
		bit          cut;

		@(posedge arst_n);
		@(posedge clk);

		// reset rates: one output per sample pair, plus one for the final sample
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h0000, 1'b1);
		// single-sample stream
		send_sample(16'h3039, 1'b1);

		// zero input rate counts as one: far too many outputs per sample
		set_rates(0, 192000);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b1);
		send_sample(16'h0064, 1'b1);

		// zero output rate: the final sample brings no output at all
		set_rates(192000, 0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'h0002, 1'b0);
		send_sample(16'h0003, 1'b1);

		// full-scale swings, then a rate change in the middle of the stream
		set_rates(44100, 48000);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h8000, 1'b0);
		set_rates(48000, 44100);
		send_sample(16'h5555, 1'b0);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h1234, 1'b1);

		// exactly the result limit per sample, then over it on the final one
		set_rates(1, 16);
		send_sample(16'h0007, 1'b0);
		send_sample(16'hFFF9, 1'b0);
		send_sample(16'h0009, 1'b1);

		// random streams, new rates every third stream; some streams are cut
		// off without a final sample, so a rate change can fall mid-stream
		items   = 0;
		streams = 0;
		while (items < RANDOM_ITEMS) begin
			if (streams % 3 == 0) begin
				ir  = pick_rate();
				orr = pick_rate();
				if (orr > 4 * ir)
					orr = 4 * ir;
				if (ir > 4 * orr)
					ir = 4 * orr;
				set_rates(ir, orr);
			end
			quiet <= (items >= 80 && items < 140);
			len = $urandom_range(12, 1);
			cut = ($urandom_range(9) == 0);
			for (int i = 0; i < len; i++)
				send_sample(draw_sample(), (i == len - 1) && !cut);
			items += len;
			streams++;
		end
		quiet <= 1'b0;

		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
